### rtl/dseq_pkg.sv
// Shared types and constants for the keypad tone sequencer.
package dseq_pkg;

  localparam int DIGITS    = 32;
  localparam int ADDR_W    = $clog2(DIGITS);
  localparam int TICK_W    = 16;
  localparam int CHAR_W    = 8;
  localparam int CODE_W    = 3;
  localparam int CFG_IDX_W = 1;

  // highest fill level: one slot of the store stays unused
  localparam logic [ADDR_W-1:0] FILL_MAX = ADDR_W'(DIGITS - 1);

  localparam logic [TICK_W-1:0] MARK_RST  = 16'd70;
  localparam logic [TICK_W-1:0] SPACE_RST = 16'd120;

  localparam logic [CFG_IDX_W-1:0] CFG_MARK  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACE = 1'b1;

  localparam logic [CODE_W-1:0] KIND_LOAD      = 3'd0;
  localparam logic [CODE_W-1:0] KIND_START_OK  = 3'd1;
  localparam logic [CODE_W-1:0] KIND_START_REJ = 3'd2;
  localparam logic [CODE_W-1:0] KIND_STOP_OK   = 3'd3;
  localparam logic [CODE_W-1:0] KIND_TICK      = 3'd4;

  localparam logic [CODE_W-1:0] ACT_NONE  = 3'd0;
  localparam logic [CODE_W-1:0] ACT_START = 3'd1;
  localparam logic [CODE_W-1:0] ACT_STOP  = 3'd2;
  localparam logic [CODE_W-1:0] ACT_DONE  = 3'd3;
  localparam logic [CODE_W-1:0] ACT_REJ   = 3'd4;
  localparam logic [CODE_W-1:0] ACT_BUSY  = 3'd5;

  typedef struct packed {
    logic [CODE_W-1:0] kind;
    logic [CHAR_W-1:0] digit;
    logic              last_digit;
  } item_t;

  typedef struct packed {
    logic [CODE_W-1:0] action;
    logic [CHAR_W-1:0] tone_digit;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CHAR_W-1:0] data;
  } store_wr_t;

endpackage

### rtl/dtmf_digit_sequencer.sv
// Top level of the keypad tone sequencer: input and result registers around the control.
//
// Use: each input transfer on in_* carries one event (load a keypad character,
// start accepted, start rejected, stop accepted, or a timer tick). Every event
// gives exactly one result transfer on out_*: an action code, plus the
// character to tone when the action is send start.
// Settings are written on cfg_*: index 0 sets the tone-on length, index 1 the
// pause length, both in ticks; a write takes effect at the clock edge where
// cfg_we is high and should be made while no event is in flight.
// Path: a taken event sits in the input register until the result register is free,
// then the control's result for it is loaded there and offered on out_*.
// Throughput: one event per cycle while not stalled; the store is read ahead
// at the next read position, so phase update, timer decrement and lookup fit one step.
// Stall: if out_ready is low the result holds, the input register still
// takes one more event, and in_ready drops until the result is taken.
// Reset (rst_n low at a clock edge): the block goes idle with an empty
// string, the timer disarmed and the lengths back to 70 and 120 ticks.
module dtmf_digit_sequencer import dseq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  item_t                in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output result_t              out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [TICK_W-1:0]    cfg_wdata
);

  item_t             in_r;
  logic              in_v_r;
  result_t           out_r;
  logic              out_v_r;
  logic              proc_fire;
  result_t           result;
  store_wr_t         wr;
  logic [ADDR_W-1:0] rd_addr;
  logic [CHAR_W-1:0] rd_data;

  assign proc_fire = in_v_r && (!out_v_r || out_ready);
  assign in_ready  = !in_v_r || proc_fire;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  dseq_store #(
    .WIDTH (CHAR_W),
    .DEPTH (DIGITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dseq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (proc_fire),
    .item      (in_r),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .rd_data   (rd_data),
    .rd_addr   (rd_addr),
    .wr        (wr),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_v_r <= 1'b1;
      end else if (proc_fire) begin
        in_v_r <= 1'b0;
      end
      if (proc_fire) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers: hold until the next transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (proc_fire) begin
      out_r <= result;
    end
  end

endmodule

### rtl/dseq_store.sv
// Generic RAM: one write port and one registered read port.
module dseq_store #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/dseq_ctrl.sv
// Sequencer control: phase machine, timer, fill and read pointers, settings.
module dseq_ctrl import dseq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  item_t                item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [TICK_W-1:0]    cfg_wdata,
  input  logic [CHAR_W-1:0]    rd_data,
  output logic [ADDR_W-1:0]    rd_addr,
  output store_wr_t            wr,
  output result_t              result
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_MARK,
    PH_STOP,
    PH_SPACE
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [ADDR_W-1:0] read_pos_r, read_pos_nxt;
  logic [ADDR_W-1:0] fill_r, fill_nxt;
  logic [TICK_W-1:0] timer_r, timer_nxt;
  logic              armed_r, armed_nxt;
  logic [TICK_W-1:0] mark_r, space_r;
  logic              fwd_v_r, fwd_v_nxt;
  logic [CHAR_W-1:0] fwd_data_r;
  logic [CHAR_W-1:0] rd_val;

  // read ahead at the next position so the store output lines up with read_pos_r
  assign rd_addr = read_pos_nxt;

  // a write to the address being read lands after the read; forward it
  assign fwd_v_nxt = wr.en && (wr.addr == read_pos_nxt);
  assign rd_val    = fwd_v_r ? fwd_data_r : rd_data;

  always_comb begin
    phase_nxt         = phase_r;
    read_pos_nxt      = read_pos_r;
    fill_nxt          = fill_r;
    timer_nxt         = timer_r;
    armed_nxt         = armed_r;
    wr                = '0;
    result.action     = ACT_NONE;
    result.tone_digit = '0;
    if (fire) begin
      unique case (item.kind)
        KIND_LOAD: begin
          if (phase_r != PH_IDLE) begin
            if (item.last_digit) begin
              result.action = ACT_BUSY;
            end
          end else begin
            if (fill_r != FILL_MAX) begin
              wr.en    = 1'b1;
              wr.addr  = fill_r;
              wr.data  = item.digit;
              fill_nxt = fill_r + 1'b1;
            end
            // read pointer rests at zero while idle; the string is never empty here
            if (item.last_digit) begin
              result.action     = ACT_START;
              result.tone_digit = (fill_r == '0) ? item.digit : rd_val;
              read_pos_nxt      = ADDR_W'(1);
              phase_nxt         = PH_START;
            end
          end
        end
        KIND_START_OK: begin
          if (phase_r == PH_START) begin
            timer_nxt = mark_r;
            armed_nxt = 1'b1;
            phase_nxt = PH_MARK;
          end
        end
        KIND_START_REJ: begin
          if (phase_r == PH_START) begin
            phase_nxt     = PH_IDLE;
            read_pos_nxt  = '0;
            fill_nxt      = '0;
            timer_nxt     = '0;
            armed_nxt     = 1'b0;
            result.action = ACT_REJ;
          end
        end
        KIND_STOP_OK: begin
          if (phase_r == PH_STOP) begin
            timer_nxt = space_r;
            armed_nxt = 1'b1;
            phase_nxt = PH_SPACE;
          end
        end
        KIND_TICK: begin
          if (armed_r) begin
            if (timer_r > TICK_W'(1)) begin
              timer_nxt = timer_r - 1'b1;
            end else begin
              // expiry; a zero count expires like a count of one
              timer_nxt = '0;
              armed_nxt = 1'b0;
              if (phase_r == PH_MARK) begin
                phase_nxt     = PH_STOP;
                result.action = ACT_STOP;
              end else if (phase_r == PH_SPACE) begin
                if (read_pos_r >= fill_r) begin
                  phase_nxt     = PH_IDLE;
                  read_pos_nxt  = '0;
                  fill_nxt      = '0;
                  result.action = ACT_DONE;
                end else begin
                  result.action     = ACT_START;
                  result.tone_digit = rd_val;
                  read_pos_nxt      = read_pos_r + 1'b1;
                  phase_nxt         = PH_START;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      read_pos_r <= '0;
      fill_r     <= '0;
      timer_r    <= '0;
      armed_r    <= 1'b0;
      mark_r     <= MARK_RST;
      space_r    <= SPACE_RST;
      fwd_v_r    <= 1'b0;
      fwd_data_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      read_pos_r <= read_pos_nxt;
      fill_r     <= fill_nxt;
      timer_r    <= timer_nxt;
      armed_r    <= armed_nxt;
      fwd_v_r    <= fwd_v_nxt;
      fwd_data_r <= wr.data;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_MARK:  mark_r  <= cfg_wdata;
          CFG_SPACE: space_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

### bench/dtmf_digit_sequencer_tb.sv
// Self-checking bench for the keypad tone sequencer: directed events, long timers, random traffic.
`timescale 1ns / 1ps

module dtmf_digit_sequencer_tb;
  import dseq_pkg::*;

  localparam int LIMIT   = 1_000_000;
  localparam int LATENCY = 2;

  // kinds the block has no use for
  localparam logic [CODE_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [CODE_W-1:0] KIND_SPARE_HI = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE, PH_START, PH_MARK, PH_STOP, PH_SPACE
  } seq_phase_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  item_t                in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  result_t              out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_MARK;
  logic [TICK_W-1:0]    cfg_wdata = '0;

  // tone sequence shadow
  seq_phase_t           seq_ph;
  logic [CHAR_W-1:0]    tone_store [DIGITS];
  int                   rd_pos;
  int                   fill_cnt;
  logic [TICK_W-1:0]    tmr_left;
  logic                 tmr_armed;
  logic [TICK_W-1:0]    mark_len;
  logic [TICK_W-1:0]    space_len;

  result_t              expected_actions [$];
  result_t              want;
  int                   idle_pct;
  int                   stall_pct;
  int                   str_left;
  int                   cycles;
  int                   errors;
  int                   items_sent;
  int                   results_seen;
  int                   strings_done;
  int                   strings_rejected;
  int                   busy_seen;

  dtmf_digit_sequencer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Timed out after %0d cycles with %0d actions outstanding",
               cycles, expected_actions.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void clear_string();
    seq_ph    = PH_IDLE;
    rd_pos    = 0;
    fill_cnt  = 0;
    tmr_armed = 1'b0;
    tmr_left  = '0;
  endfunction

  function automatic result_t next_tone();
    result_t r;
    r = '0;
    if (rd_pos >= fill_cnt) begin
      clear_string();
      r.action = ACT_DONE;
      strings_done++;
    end else begin
      r.action     = ACT_START;
      r.tone_digit = tone_store[rd_pos];
      rd_pos++;
      seq_ph = PH_START;
    end
    return r;
  endfunction

  // advance the shadow by one event and return the action it gives
  function automatic result_t tone_step(item_t it);
    result_t r;
    r = '0;
    case (it.kind)
      KIND_LOAD: begin
        if (seq_ph != PH_IDLE) begin
          if (it.last_digit) begin
            r.action = ACT_BUSY;
            busy_seen++;
          end
        end else begin
          if (fill_cnt < DIGITS - 1) begin
            tone_store[fill_cnt] = it.digit;
            fill_cnt++;
          end
          if (it.last_digit) begin
            rd_pos = 0;
            r = next_tone();
          end
        end
      end
      KIND_START_OK: begin
        if (seq_ph == PH_START) begin
          tmr_left  = mark_len;
          tmr_armed = 1'b1;
          seq_ph    = PH_MARK;
        end
      end
      KIND_START_REJ: begin
        if (seq_ph == PH_START) begin
          clear_string();
          r.action = ACT_REJ;
          strings_rejected++;
        end
      end
      KIND_STOP_OK: begin
        if (seq_ph == PH_STOP) begin
          tmr_left  = space_len;
          tmr_armed = 1'b1;
          seq_ph    = PH_SPACE;
        end
      end
      KIND_TICK: begin
        if (tmr_armed) begin
          if (tmr_left > 1) begin
            tmr_left = tmr_left - 1'b1;
          end else begin
            // a zero length expires like a length of one
            tmr_left  = '0;
            tmr_armed = 1'b0;
            if (seq_ph == PH_MARK) begin
              seq_ph   = PH_STOP;
              r.action = ACT_STOP;
            end else if (seq_ph == PH_SPACE) begin
              r = next_tone();
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // mostly well-formed traffic for the current phase, with some noise
  function automatic item_t pick_item();
    item_t it;
    int    roll;
    roll          = $urandom_range(99);
    it.digit      = CHAR_W'($urandom);
    it.last_digit = 1'b0;
    it.kind       = KIND_TICK;
    if (roll < 8) begin
      it.kind       = CODE_W'($urandom);
      it.last_digit = 1'($urandom);
    end else begin
      case (seq_ph)
        PH_IDLE: begin
          if (str_left == 0)
            str_left = ($urandom_range(9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
          str_left--;
          it.kind       = KIND_LOAD;
          it.last_digit = (str_left == 0);
        end
        PH_START: it.kind = (roll < 11) ? KIND_START_REJ : KIND_START_OK;
        PH_STOP:  it.kind = KIND_STOP_OK;
        default:  it.kind = KIND_TICK;
      endcase
    end
    return it;
  endfunction

  // result side: random stalls and the action and tone_digit check
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_actions.size() == 0) begin
        $error("unexpected result: action %0d tone_digit 0x%02h",
               out_data.action, out_data.tone_digit);
        errors++;
      end else begin
        want = expected_actions.pop_front();
        if (out_data.action !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, out_data.action);
          errors++;
        end
        if (out_data.tone_digit !== want.tone_digit) begin
          $error("tone_digit: expected 0x%02h, got 0x%02h",
                 want.tone_digit, out_data.tone_digit);
          errors++;
        end
      end
    end
    out_ready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);
  end

  // returns in the step of the transfer with valid still high
  task automatic send_item(logic [CODE_W-1:0] kind, logic [CHAR_W-1:0] dig, logic last);
    item_t it;
    it.kind       = kind;
    it.digit      = dig;
    it.last_digit = last;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_actions.push_back(tone_step(it));
    items_sent++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(KIND_TICK, CHAR_W'($urandom), 1'($urandom));
  endtask

  // hold the input off until every action has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_actions.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MARK) mark_len = val;
    else space_len = val;
  endtask

  task automatic test_reset_lengths();
    idle_pct  = 0;
    stall_pct = 0;
    send_item(KIND_LOAD, 8'h31, 1'b1);
    send_item(KIND_START_OK, 8'h00, 1'b0);
    send_ticks(int'(MARK_RST));
    send_item(KIND_STOP_OK, 8'h00, 1'b0);
    send_ticks(int'(SPACE_RST));
    drain_results();
  endtask

  task automatic test_directed();
    idle_pct  = 16;
    stall_pct = 16;
    write_reg(CFG_MARK, 16'd1);
    write_reg(CFG_SPACE, 16'd0);
    send_item(KIND_TICK, 8'h00, 1'b0);
    for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
      send_item(CODE_W'(k), 8'hFF, 1'b1);
    send_item(KIND_START_OK, 8'h00, 1'b0);
    send_item(KIND_START_REJ, 8'h00, 1'b0);
    send_item(KIND_STOP_OK, 8'h00, 1'b0);
    send_item(KIND_LOAD, 8'hFF, 1'b0);
    send_item(KIND_LOAD, 8'h00, 1'b0);
    send_item(KIND_LOAD, 8'hA5, 1'b1);
    // loads while sending are dropped
    send_item(KIND_LOAD, 8'h5A, 1'b0);
    send_item(KIND_LOAD, 8'h5A, 1'b1);
    send_item(KIND_STOP_OK, 8'h00, 1'b0);
    send_item(KIND_TICK, 8'h00, 1'b0);
    send_item(KIND_START_OK, 8'h00, 1'b0);
    send_item(KIND_START_OK, 8'h00, 1'b0);
    send_item(KIND_TICK, 8'h00, 1'b0);
    send_item(KIND_START_REJ, 8'h00, 1'b0);
    send_item(KIND_STOP_OK, 8'h00, 1'b0);
    send_item(KIND_TICK, 8'h00, 1'b0);
    send_item(KIND_START_OK, 8'h00, 1'b0);
    send_item(KIND_TICK, 8'h00, 1'b0);
    send_item(KIND_STOP_OK, 8'h00, 1'b0);
    send_item(KIND_TICK, 8'h00, 1'b0);
    send_item(KIND_START_REJ, 8'h00, 1'b0);
    // single digit string through to done
    send_item(KIND_LOAD, 8'h3C, 1'b1);
    send_item(KIND_START_OK, 8'h00, 1'b0);
    send_item(KIND_TICK, 8'h00, 1'b0);
    send_item(KIND_STOP_OK, 8'h00, 1'b0);
    send_item(KIND_TICK, 8'h00, 1'b0);
    drain_results();
  endtask

  task automatic test_store_full();
    idle_pct  = 16;
    stall_pct = 16;
    write_reg(CFG_MARK, 16'd2);
    write_reg(CFG_SPACE, 16'd1);
    for (int i = 1; i <= DIGITS + 3; i++)
      send_item(KIND_LOAD, CHAR_W'($urandom), i == DIGITS + 3);
    repeat (DIGITS - 1) begin
      send_item(KIND_START_OK, 8'h00, 1'b0);
      send_ticks(2);
      send_item(KIND_STOP_OK, 8'h00, 1'b0);
      send_ticks(1);
    end
    drain_results();
  endtask

  // a mark length past one byte, so its count borrows across the upper bits
  task automatic test_long_timers();
    idle_pct  = 0;
    stall_pct = 0;
    write_reg(CFG_MARK, 16'h0100);
    write_reg(CFG_SPACE, 16'h0080);
    send_item(KIND_LOAD, 8'h69, 1'b1);
    send_item(KIND_START_OK, 8'h00, 1'b0);
    send_ticks(int'(16'h0100));
    send_item(KIND_STOP_OK, 8'h00, 1'b0);
    send_ticks(int'(16'h0080));
    drain_results();
  endtask

  task automatic test_random(int n, int idle, int stall);
    item_t it;
    write_reg(CFG_MARK, TICK_W'($urandom_range(1, 6)));
    write_reg(CFG_SPACE, TICK_W'($urandom_range(1, 6)));
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) begin
      it = pick_item();
      send_item(it.kind, it.digit, it.last_digit);
    end
    drain_results();
  endtask

  initial begin
    mark_len  = MARK_RST;
    space_len = SPACE_RST;
    clear_string();
    idle_pct  = 0;
    stall_pct = 0;
    str_left  = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_lengths();
    test_directed();
    test_store_full();
    test_long_timers();
    test_random(165, 0, 0);
    test_random(165, 49, 0);
    test_random(165, 0, 49);
    test_random(165, 16, 16);

    $display("Sent %0d events, checked %0d actions in %0d cycles.",
             items_sent, results_seen, cycles);
    $display("Strings finished %0d, rejected %0d; busy answers %0d.",
             strings_done, strings_rejected, busy_seen);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/dseq_pkg.sv
rtl/dseq_store.sv
rtl/dseq_ctrl.sv
rtl/dtmf_digit_sequencer.sv
bench/dtmf_digit_sequencer_tb.sv
